// ----- hw/rtl/sprite_dest_rect_transform_assert.svh -----
// Assertion macros used by the sprite destination rectangle top level.
`ifndef SPRITE_DEST_RECT_TRANSFORM_ASSERT_SVH
`define SPRITE_DEST_RECT_TRANSFORM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SDRT_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdrt assertion failed");

// Next-cycle implication, disabled during reset.
`define SDRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdrt assertion failed");

`endif

// ----- hw/rtl/sdrt_pkg.sv -----
// Types, constants and helpers for the sprite destination rectangle transform.
`timescale 1ns / 1ps
package sdrt_pkg;

   localparam int DIV_STEPS = 29;
   localparam int ATAN_MAX  = 24;
   localparam int CORDIC_W  = 34;

   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic [12:0] PPU_DEFAULT = 13'd100;

   // atan(2^-i) in degrees, Q.24
   localparam logic [29:0] ATAN_DEG_Q24 [ATAN_MAX] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
      30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
      30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
      30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229, 30'd115
   };

   typedef enum logic [3:0] {
      CSR_ENABLE        = 4'd0,
      CSR_REGION_WIDTH  = 4'd1,
      CSR_REGION_HEIGHT = 4'd2,
      CSR_PIXELS_PER_UNIT = 4'd3,
      CSR_OFFSET_X      = 4'd4,
      CSR_OFFSET_Y      = 4'd5,
      CSR_PIVOT_X       = 4'd6,
      CSR_PIVOT_Y       = 4'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      DIV_IDLE = 4'b0001,
      DIV_LOAD = 4'b0010,
      DIV_RUN  = 4'b0100,
      DIV_DONE = 4'b1000
   } div_state_type;

   typedef struct packed {
      logic               busy;
      logic               drawn;
      logic [28:0]        base_w;
      logic [28:0]        base_h;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic [16:0]        pivot_x;
      logic [16:0]        pivot_y;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] spin;
   } sb_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

// ----- hw/rtl/sprite_dest_rect_transform.sv -----
// Top level of the sprite destination rectangle transform pipeline.
`timescale 1ns / 1ps
`include "sprite_dest_rect_transform_assert.svh"

// Sprite destination rectangle transform. One sprite pose enters per beat on
// the req_ channel and one rectangle leaves per beat on the rsp_ channel, in
// order. The pipe takes a new pose every cycle unless the output stalls or a
// divide runs; its stages are angle reduction, one stage per CORDIC
// iteration, rounding, then five multiply/add stages ending in the output
// register. The whole pipe advances together whenever the output register
// is empty or being taken, so a stall holds every stage in place. Writing
// region_width, region_height or pixels_per_unit starts a 29-step serial
// divide of the base size; csr_ready and req_ready stay low while the divider
// loads, runs and stores the result. Program the registers only while the
// pipe is empty. drawn is low when the sprite is disabled or the region is
// empty; the geometry fields are still computed in that case.
module sprite_dest_rect_transform import sdrt_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [15:0] req_tilt_x_deg,
   input  logic signed [15:0] req_tilt_y_deg,
   input  logic signed [15:0] req_spin_z_deg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_dest_x,
   output logic signed [31:0] rsp_dest_y,
   output logic signed [31:0] rsp_dest_w,
   output logic signed [31:0] rsp_dest_h,
   output logic signed [15:0] rsp_spin_out_deg,
   output logic               rsp_drawn
);

   localparam int LAT = CORDIC_ITERATIONS + 2;  // CORDIC depth
   localparam int TOT = LAT + 5;                // total pipe depth

   cfg_type cfg;
   logic    adv;
   logic [TOT-1:0] vld_ff, vld_in;
   sb_type  sb_ff [LAT];
   logic signed [17:0] cos_ty, cos_tx, cos_z, sin_z;

   sdrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance every stage when the output register can move
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv && !cfg.busy;

   assign vld_in = {vld_ff[TOT-2:0], req_valid && req_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // sideband fields ride alongside the CORDIC stages
   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0].pos_x   <= req_pos_x;
         sb_ff[0].pos_y   <= req_pos_y;
         sb_ff[0].scale_x <= req_scale_x;
         sb_ff[0].scale_y <= req_scale_y;
         sb_ff[0].spin    <= req_spin_z_deg;
         for (int k = 1; k < LAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // width foreshortening uses the Y tilt, height the X tilt
   sdrt_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_ty (
      .clock (clock), .advance (adv), .angle (req_tilt_y_deg),
      .cos_out (cos_ty), .sin_out ()
   );
   sdrt_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_tx (
      .clock (clock), .advance (adv), .angle (req_tilt_x_deg),
      .cos_out (cos_tx), .sin_out ()
   );
   sdrt_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_z (
      .clock (clock), .advance (adv), .angle (req_spin_z_deg),
      .cos_out (cos_z), .sin_out (sin_z)
   );

   // P1: floor the tilt cosines, scale them and the local offset
   logic [16:0]        fx, fy;
   logic signed [47:0] oxp, oyp;
   logic signed [33:0] p1_sfx_ff, p1_sfx_in, p1_sfy_ff, p1_sfy_in;
   logic signed [45:0] p1_ox_ff, p1_ox_in, p1_oy_ff, p1_oy_in;
   logic signed [17:0] p1_cz_ff, p1_sz_ff;
   logic signed [31:0] p1_px_ff, p1_py_ff;
   logic signed [15:0] p1_spin_ff;

   always_comb begin
      fx        = cos_ty[17] ? 17'd0 : cos_ty[16:0];
      fy        = cos_tx[17] ? 17'd0 : cos_tx[16:0];
      p1_sfx_in = sb_ff[LAT-1].scale_x * $signed({1'b0, fx});
      p1_sfy_in = sb_ff[LAT-1].scale_y * $signed({1'b0, fy});
      oxp       = 48'(cfg.offset_x) * 48'(sb_ff[LAT-1].scale_x);
      oyp       = 48'(cfg.offset_y) * 48'(sb_ff[LAT-1].scale_y);
      p1_ox_in  = 46'(oxp >>> 2);
      p1_oy_in  = 46'(oyp >>> 2);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_sfx_ff  <= p1_sfx_in;
         p1_sfy_ff  <= p1_sfy_in;
         p1_ox_ff   <= p1_ox_in;
         p1_oy_ff   <= p1_oy_in;
         p1_cz_ff   <= cos_z;
         p1_sz_ff   <= sin_z;
         p1_px_ff   <= sb_ff[LAT-1].pos_x;
         p1_py_ff   <= sb_ff[LAT-1].pos_y;
         p1_spin_ff <= sb_ff[LAT-1].spin;
      end
   end

   // P2: size products and rotation partial products
   logic signed [63:0] p2_wp_ff, p2_hp_ff, p2_m1_ff, p2_m2_ff, p2_m3_ff, p2_m4_ff;
   logic signed [31:0] p2_px_ff, p2_py_ff;
   logic signed [15:0] p2_spin_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_wp_ff   <= $signed({1'b0, cfg.base_w}) * p1_sfx_ff;
         p2_hp_ff   <= $signed({1'b0, cfg.base_h}) * p1_sfy_ff;
         p2_m1_ff   <= p1_ox_ff * p1_cz_ff;
         p2_m2_ff   <= p1_oy_ff * p1_sz_ff;
         p2_m3_ff   <= p1_ox_ff * p1_sz_ff;
         p2_m4_ff   <= p1_oy_ff * p1_cz_ff;
         p2_px_ff   <= p1_px_ff;
         p2_py_ff   <= p1_py_ff;
         p2_spin_ff <= p1_spin_ff;
      end
   end

   // P3: round sizes to Q16.16, combine the rotated offset
   logic signed [39:0] p3_w_ff, p3_w_in, p3_h_ff, p3_h_in;
   logic signed [57:0] p3_rx_ff, p3_rx_in, p3_ry_ff, p3_ry_in;
   logic signed [31:0] p3_px_ff, p3_py_ff;
   logic signed [15:0] p3_spin_ff;

   always_comb begin
      p3_w_in  = 40'((p2_wp_ff + 64'sd8388608) >>> 24);
      p3_h_in  = 40'((p2_hp_ff + 64'sd8388608) >>> 24);
      p3_rx_in = 58'((p2_m1_ff - p2_m2_ff) >>> 6);
      p3_ry_in = 58'((p2_m3_ff + p2_m4_ff) >>> 6);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_w_ff    <= p3_w_in;
         p3_h_ff    <= p3_h_in;
         p3_rx_ff   <= p3_rx_in;
         p3_ry_ff   <= p3_ry_in;
         p3_px_ff   <= p2_px_ff;
         p3_py_ff   <= p2_py_ff;
         p3_spin_ff <= p2_spin_ff;
      end
   end

   // P4: pivot share of the size, position plus rotated offset
   logic signed [57:0] p4_wpv_ff, p4_hpv_ff;
   logic signed [63:0] p4_bx_ff, p4_bx_in, p4_by_ff, p4_by_in;
   logic signed [39:0] p4_w_ff, p4_h_ff;
   logic signed [15:0] p4_spin_ff;

   always_comb begin
      p4_bx_in = (64'(p3_px_ff) <<< 16) + 64'(p3_rx_ff);
      p4_by_in = (64'(p3_py_ff) <<< 16) + 64'(p3_ry_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_wpv_ff  <= p3_w_ff * $signed({1'b0, cfg.pivot_x});
         p4_hpv_ff  <= p3_h_ff * $signed({1'b0, cfg.pivot_y});
         p4_bx_ff   <= p4_bx_in;
         p4_by_ff   <= p4_by_in;
         p4_w_ff    <= p3_w_ff;
         p4_h_ff    <= p3_h_ff;
         p4_spin_ff <= p3_spin_ff;
      end
   end

   // P5: output register, round to Q16.16 and saturate
   logic signed [31:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_w_ff, o_h_ff;
   logic signed [15:0] o_spin_ff;
   logic               o_drawn_ff;

   always_comb begin
      o_x_in = sat32((p4_bx_ff - 64'(p4_wpv_ff) + 64'sd32768) >>> 16);
      o_y_in = sat32((p4_by_ff - 64'(p4_hpv_ff) + 64'sd32768) >>> 16);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_x_ff     <= o_x_in;
         o_y_ff     <= o_y_in;
         o_w_ff     <= sat32(64'(p4_w_ff));
         o_h_ff     <= sat32(64'(p4_h_ff));
         o_spin_ff  <= p4_spin_ff;
         o_drawn_ff <= cfg.drawn;
      end
   end

   assign rsp_valid        = vld_ff[TOT-1];
   assign rsp_dest_x       = o_x_ff;
   assign rsp_dest_y       = o_y_ff;
   assign rsp_dest_w       = o_w_ff;
   assign rsp_dest_h       = o_h_ff;
   assign rsp_spin_out_deg = o_spin_ff;
   assign rsp_drawn        = o_drawn_ff;

   // no pose taken while the base size is being recomputed
   `SDRT_ASSERT_HOLDS(a_no_req_while_busy, clock, reset, cfg.busy, !req_ready)
   // the divider only starts from a register write beat
   `SDRT_ASSERT_HOLDS(a_busy_from_write, clock, reset, $rose(cfg.busy), $past(csr_valid && csr_ready))
   // a stalled pipe keeps its first stage occupied
   `SDRT_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, vld_ff[0] && !adv, vld_ff[0])

endmodule

// ----- hw/rtl/sdrt_csr.sv -----
// Configuration registers and serial base-size divider.
`timescale 1ns / 1ps
module sdrt_csr import sdrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   logic               enable_ff, enable_in;
   logic [12:0]        rw_ff, rw_in, rh_ff, rh_in, ppu_ff, ppu_in;
   logic signed [31:0] offx_ff, offx_in, offy_ff, offy_in;
   logic [16:0]        pivx_ff, pivx_in, pivy_ff, pivy_in;
   logic [28:0]        bw_ff, bw_in, bh_ff, bh_in;
   div_state_type      state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [28:0]        shw_ff, shw_in, shh_ff, shh_in;
   logic [12:0]        remw_ff, remw_in, remh_ff, remh_in;
   logic               wr, start;
   logic [12:0]        divisor;
   logic [13:0]        trial_w, trial_h;
   logic               qw, qh;

   function automatic logic [16:0] clamp_pivot(input logic [16:0] v);
      return (v[16] && (v[15:0] != 16'd0)) ? 17'd65536 : v;
   endfunction

   assign csr_ready = (state_ff == DIV_IDLE);
   assign wr        = csr_valid && csr_ready;
   assign divisor   = (ppu_ff == 13'd0) ? PPU_DEFAULT : ppu_ff;

   // register writes
   always_comb begin
      enable_in = enable_ff;
      rw_in     = rw_ff;
      rh_in     = rh_ff;
      ppu_in    = ppu_ff;
      offx_in   = offx_ff;
      offy_in   = offy_ff;
      pivx_in   = pivx_ff;
      pivy_in   = pivy_ff;
      start     = 1'b0;
      if (wr) begin
         unique case (csr_index)
            CSR_ENABLE:          enable_in = csr_wdata[0];
            CSR_REGION_WIDTH: begin
               rw_in = csr_wdata[12:0];
               start = 1'b1;
            end
            CSR_REGION_HEIGHT: begin
               rh_in = csr_wdata[12:0];
               start = 1'b1;
            end
            CSR_PIXELS_PER_UNIT: begin
               ppu_in = csr_wdata[12:0];
               start  = 1'b1;
            end
            CSR_OFFSET_X:        offx_in = csr_wdata;
            CSR_OFFSET_Y:        offy_in = csr_wdata;
            CSR_PIVOT_X:         pivx_in = clamp_pivot(csr_wdata[16:0]);
            CSR_PIVOT_Y:         pivy_in = clamp_pivot(csr_wdata[16:0]);
            default:             start = 1'b0;
         endcase
      end
   end

   // restoring divider, one quotient bit per cycle for both dimensions
   always_comb begin
      trial_w   = {remw_ff, shw_ff[28]};
      trial_h   = {remh_ff, shh_ff[28]};
      qw        = trial_w >= {1'b0, divisor};
      qh        = trial_h >= {1'b0, divisor};
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      shw_in    = shw_ff;
      shh_in    = shh_ff;
      remw_in   = remw_ff;
      remh_in   = remh_ff;
      bw_in     = bw_ff;
      bh_in     = bh_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) state_in = DIV_LOAD;
         end
         DIV_LOAD: begin
            shw_in   = {rw_ff, 16'd0};
            shh_in   = {rh_ff, 16'd0};
            remw_in  = '0;
            remh_in  = '0;
            cnt_in   = '0;
            state_in = DIV_RUN;
         end
         DIV_RUN: begin
            remw_in = qw ? 13'(trial_w - {1'b0, divisor}) : trial_w[12:0];
            remh_in = qh ? 13'(trial_h - {1'b0, divisor}) : trial_h[12:0];
            shw_in  = {shw_ff[27:0], qw};
            shh_in  = {shh_ff[27:0], qh};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = DIV_DONE;
         end
         DIV_DONE: begin
            bw_in    = shw_ff;
            bh_in    = shh_ff;
            state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         rw_ff     <= '0;
         rh_ff     <= '0;
         ppu_ff    <= PPU_DEFAULT;
         offx_ff   <= '0;
         offy_ff   <= '0;
         pivx_ff   <= 17'd32768;
         pivy_ff   <= 17'd32768;
         bw_ff     <= '0;
         bh_ff     <= '0;
         state_ff  <= DIV_IDLE;
         cnt_ff    <= '0;
      end else begin
         enable_ff <= enable_in;
         rw_ff     <= rw_in;
         rh_ff     <= rh_in;
         ppu_ff    <= ppu_in;
         offx_ff   <= offx_in;
         offy_ff   <= offy_in;
         pivx_ff   <= pivx_in;
         pivy_ff   <= pivy_in;
         bw_ff     <= bw_in;
         bh_ff     <= bh_in;
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shw_ff  <= shw_in;
      shh_ff  <= shh_in;
      remw_ff <= remw_in;
      remh_ff <= remh_in;
   end

   always_comb begin
      cfg.busy     = (state_ff != DIV_IDLE);
      cfg.drawn    = enable_ff && (rw_ff != 13'd0) && (rh_ff != 13'd0);
      cfg.base_w   = bw_ff;
      cfg.base_h   = bh_ff;
      cfg.offset_x = offx_ff;
      cfg.offset_y = offy_ff;
      cfg.pivot_x  = pivx_ff;
      cfg.pivot_y  = pivy_ff;
   end

endmodule

// ----- hw/rtl/sdrt_cordic.sv -----
// Pipelined degree-domain CORDIC: angle reduction, iterations, rounding.
`timescale 1ns / 1ps
module sdrt_cordic import sdrt_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [15:0] angle,
   output logic signed [17:0] cos_out,
   output logic signed [17:0] sin_out
);

   logic signed [17:0]         a_ext, r1, r2, r3;
   logic                       fold;
   logic signed [CORDIC_W-1:0] x_ff [ITERATIONS+1];
   logic signed [CORDIC_W-1:0] y_ff [ITERATIONS+1];
   logic signed [CORDIC_W-1:0] z_ff [ITERATIONS+1];
   logic                       neg_ff [ITERATIONS+1];
   logic signed [CORDIC_W-1:0] x_in [ITERATIONS+1];
   logic signed [CORDIC_W-1:0] y_in [ITERATIONS+1];
   logic signed [CORDIC_W-1:0] z_in [ITERATIONS+1];
   logic                       neg_in [ITERATIONS+1];
   logic signed [CORDIC_W-1:0] xn, yn, xr, yr;
   logic signed [17:0]         cos_ff, cos_in, sin_ff, sin_in;

   // reduce to (-180,180], then fold to [-90,90] with a half-turn
   always_comb begin
      a_ext = 18'(angle);
      if (a_ext < -18'sd23040)      r1 = a_ext + 18'sd46080;
      else if (a_ext < 18'sd0)      r1 = a_ext + 18'sd23040;
      else if (a_ext >= 18'sd23040) r1 = a_ext - 18'sd23040;
      else                          r1 = a_ext;
      r2   = (r1 > 18'sd11520) ? r1 - 18'sd23040 : r1;
      r3   = r2;
      fold = 1'b0;
      if (r2 > 18'sd5760) begin
         r3   = r2 - 18'sd11520;
         fold = 1'b1;
      end else if (r2 < -18'sd5760) begin
         r3   = r2 + 18'sd11520;
         fold = 1'b1;
      end
      x_in[0]   = CORDIC_X0;
      y_in[0]   = '0;
      z_in[0]   = CORDIC_W'(r3) <<< 18;
      neg_in[0] = fold;
   end

   for (genvar i = 1; i <= ITERATIONS; i++) begin : g_iter
      logic signed [CORDIC_W-1:0] dx, dy, ang;
      always_comb begin
         dx  = y_ff[i-1] >>> (i - 1);
         dy  = x_ff[i-1] >>> (i - 1);
         ang = $signed(CORDIC_W'(ATAN_DEG_Q24[i-1]));
         if (z_ff[i-1] >= 0) begin
            x_in[i] = x_ff[i-1] - dx;
            y_in[i] = y_ff[i-1] + dy;
            z_in[i] = z_ff[i-1] - ang;
         end else begin
            x_in[i] = x_ff[i-1] + dx;
            y_in[i] = y_ff[i-1] - dy;
            z_in[i] = z_ff[i-1] + ang;
         end
         neg_in[i] = neg_ff[i-1];
      end
   end

   // undo the fold, round to Q.16 and clamp to the unit range
   always_comb begin
      xn = neg_ff[ITERATIONS] ? -x_ff[ITERATIONS] : x_ff[ITERATIONS];
      yn = neg_ff[ITERATIONS] ? -y_ff[ITERATIONS] : y_ff[ITERATIONS];
      xr = (xn + 34'sd8192) >>> 14;
      yr = (yn + 34'sd8192) >>> 14;
      if (xr > 34'sd65536)       cos_in = 18'sd65536;
      else if (xr < -34'sd65536) cos_in = -18'sd65536;
      else                       cos_in = xr[17:0];
      if (yr > 34'sd65536)       sin_in = 18'sd65536;
      else if (yr < -34'sd65536) sin_in = -18'sd65536;
      else                       sin_in = yr[17:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= ITERATIONS; k++) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            z_ff[k]   <= z_in[k];
            neg_ff[k] <= neg_in[k];
         end
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- dv/tb_sprite_dest_rect_transform.sv -----
// Self-checking testbench for the sprite destination rectangle transform.
`timescale 1ns / 1ps

module tb_sprite_dest_rect_transform;
   import sdrt_pkg::*;

   localparam int CORDIC_STEPS = 16;
   // Leave extra room for the pipe once the queue drains.
   localparam int SETTLE_CYCLES = CORDIC_STEPS + 20;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [3:0] CSR_INDEX_UNUSED = 4'd8;
   localparam logic [3:0] CSR_INDEX_HIGHEST = 4'd15;
   localparam longint FULL_TURN = 23040;   // 360 degrees in Q10.6
   localparam longint HALF_TURN = 11520;
   localparam longint QUARTER_TURN = 5760;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] tilt_x;
      logic signed [15:0] tilt_y;
      logic signed [15:0] spin_z;
   } pose_type;

   typedef struct {
      logic signed [31:0] dest_x;
      logic signed [31:0] dest_y;
      logic signed [31:0] dest_w;
      logic signed [31:0] dest_h;
      logic signed [15:0] spin;
      logic               drawn;
   } rect_type;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [3:0]         csr_index;
   logic [31:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_pos_x;
   logic signed [31:0] req_pos_y;
   logic signed [15:0] req_scale_x;
   logic signed [15:0] req_scale_y;
   logic signed [15:0] req_tilt_x_deg;
   logic signed [15:0] req_tilt_y_deg;
   logic signed [15:0] req_spin_z_deg;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_dest_x;
   logic signed [31:0] rsp_dest_y;
   logic signed [31:0] rsp_dest_w;
   logic signed [31:0] rsp_dest_h;
   logic signed [15:0] rsp_spin_out_deg;
   logic               rsp_drawn;

   // Shadow copy of the register file, updated on each accepted write beat.
   logic         sh_enable;
   logic [12:0]  sh_region_w;
   logic [12:0]  sh_region_h;
   logic [12:0]  sh_ppu;
   longint       sh_offset_x;
   longint       sh_offset_y;
   longint       sh_pivot_x;
   longint       sh_pivot_y;

   rect_type     pending_rects[$];
   int           error_count;
   int           cycle_count;
   int           ready_hold;

   sprite_dest_rect_transform #(.CORDIC_ITERATIONS(CORDIC_STEPS)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Clip a wide value into the signed 32-bit Q16.16 range.
   function automatic logic signed [31:0] clip_q16(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Rotation-mode CORDIC on a Q10.6 angle; cos and sin come back in Q.16.
   task automatic unit_trig(input longint angle, output longint cos16, output longint sin16);
      longint r;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      bit     flip;
      r = angle % FULL_TURN;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (r < 0) r += FULL_TURN;
      if (r > HALF_TURN) r -= FULL_TURN;
      // Fold into the right half plane by a half turn, negate at the end.
      if (r > QUARTER_TURN) begin
         r -= HALF_TURN;
         flip = 1'b1;
      end else if (r < -QUARTER_TURN) begin
         r += HALF_TURN;
         flip = 1'b1;
      end
      z = r * 262144;
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_MAX; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(ATAN_DEG_Q24[i]);
         end else begin
            x += dx;
            y -= dy;
            z += longint'(ATAN_DEG_Q24[i]);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cos16 = (x + 8192) >>> 14;
      sin16 = (y + 8192) >>> 14;
      if (cos16 > 65536) cos16 = 65536;
      if (cos16 < -65536) cos16 = -65536;
      if (sin16 > 65536) sin16 = 65536;
      if (sin16 < -65536) sin16 = -65536;
   endtask

   task automatic predict_rect(input pose_type p, output rect_type r);
      longint ppu;
      longint base_w;
      longint base_h;
      longint fold_w;
      longint fold_h;
      longint cos_z;
      longint sin_z;
      longint unused;
      longint w16;
      longint h16;
      longint off_x;
      longint off_y;
      longint rot_x;
      longint rot_y;
      longint acc_x;
      longint acc_y;
      ppu = (sh_ppu != 0) ? longint'(sh_ppu) : 100;
      base_w = (longint'(sh_region_w) * 65536) / ppu;
      base_h = (longint'(sh_region_h) * 65536) / ppu;
      // Tilt about Y narrows the width, tilt about X flattens the height.
      unit_trig(longint'(p.tilt_y), fold_w, unused);
      unit_trig(longint'(p.tilt_x), fold_h, unused);
      if (fold_w < 0) fold_w = 0;
      if (fold_h < 0) fold_h = 0;
      w16 = (base_w * longint'(p.scale_x) * fold_w + (64'sd1 << 23)) >>> 24;
      h16 = (base_h * longint'(p.scale_y) * fold_h + (64'sd1 << 23)) >>> 24;
      unit_trig(longint'(p.spin_z), cos_z, sin_z);
      off_x = (sh_offset_x * longint'(p.scale_x)) >>> 2;
      off_y = (sh_offset_y * longint'(p.scale_y)) >>> 2;
      rot_x = off_x * cos_z - off_y * sin_z;
      rot_y = off_x * sin_z + off_y * cos_z;
      acc_x = longint'(p.pos_x) * 65536 + (rot_x >>> 6) - w16 * sh_pivot_x;
      acc_y = longint'(p.pos_y) * 65536 + (rot_y >>> 6) - h16 * sh_pivot_y;
      r.dest_x = clip_q16((acc_x + 32768) >>> 16);
      r.dest_y = clip_q16((acc_y + 32768) >>> 16);
      r.dest_w = clip_q16(w16);
      r.dest_h = clip_q16(h16);
      r.spin = p.spin_z;
      r.drawn = sh_enable && sh_region_w != 0 && sh_region_h != 0;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Write one register beat and mirror it into the shadow copy.
   task automatic write_reg(input logic [3:0] index, input logic [31:0] data);
      longint piv;
      piv = longint'(data[16:0]);
      if (piv > 65536) piv = 65536;
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_ENABLE: sh_enable = data[0];
         CSR_REGION_WIDTH: sh_region_w = data[12:0];
         CSR_REGION_HEIGHT: sh_region_h = data[12:0];
         CSR_PIXELS_PER_UNIT: sh_ppu = data[12:0];
         CSR_OFFSET_X: sh_offset_x = longint'(signed'(data));
         CSR_OFFSET_Y: sh_offset_y = longint'(signed'(data));
         CSR_PIVOT_X: sh_pivot_x = piv;
         CSR_PIVOT_Y: sh_pivot_y = piv;
         default: ;
      endcase
      // Idle before the next write beat.
      @(posedge clock);
   endtask

   task automatic load_config(input logic en, input logic [31:0] rw, input logic [31:0] rh,
                              input logic [31:0] ppu, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] pvx,
                              input logic [31:0] pvy);
      write_reg(CSR_ENABLE, {31'd0, en});
      write_reg(CSR_REGION_WIDTH, rw);
      write_reg(CSR_REGION_HEIGHT, rh);
      write_reg(CSR_PIXELS_PER_UNIT, ppu);
      write_reg(CSR_OFFSET_X, ox);
      write_reg(CSR_OFFSET_Y, oy);
      write_reg(CSR_PIVOT_X, pvx);
      write_reg(CSR_PIVOT_Y, pvy);
   endtask

   // Send one pose beat; valid stays high into the next call when there is no gap.
   task automatic send_pose(input pose_type p);
      int       gap;
      rect_type want;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_pos_x <= p.pos_x;
      req_pos_y <= p.pos_y;
      req_scale_x <= p.scale_x;
      req_scale_y <= p.scale_y;
      req_tilt_x_deg <= p.tilt_x;
      req_tilt_y_deg <= p.tilt_y;
      req_spin_z_deg <= p.spin_z;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_rect(p, want);
      pending_rects.push_back(want);
   endtask

   // Drop valid and wait until the pipe is empty before touching registers.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pose_type mk_pose(input logic signed [31:0] px,
                                        input logic signed [31:0] py,
                                        input logic signed [15:0] sx,
                                        input logic signed [15:0] sy,
                                        input logic signed [15:0] tx,
                                        input logic signed [15:0] ty,
                                        input logic signed [15:0] tz);
      pose_type p;
      p.pos_x = px;
      p.pos_y = py;
      p.scale_x = sx;
      p.scale_y = sy;
      p.tilt_x = tx;
      p.tilt_y = ty;
      p.spin_z = tz;
      return p;
   endfunction

   function automatic logic signed [15:0] rand_angle();
      int roll;
      roll = $urandom_range(0, 9);
      // Hit the quarter and half turns exactly now and then.
      if (roll == 0) return 16'(($urandom_range(0, 8) - 4) * QUARTER_TURN);
      return 16'($urandom_range(0, 46080) - 23040);
   endfunction

   function automatic logic signed [15:0] rand_scale();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return 16'($urandom_range(0, 1024) - 512);
      return 16'($urandom);
   endfunction

   function automatic pose_type rand_pose();
      return mk_pose($urandom, $urandom, rand_scale(), rand_scale(),
                     rand_angle(), rand_angle(), rand_angle());
   endfunction

   task automatic test_reset_state();
      // Reset config: disabled, empty region, default ppu and centered pivot.
      send_pose(mk_pose(32'sh0001_0000, -32'sh0002_0000, 16'sh0100, 16'sh0100, 0, 0, 0));
      send_pose(mk_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000, 0, 0, 16'sd5760));
      drain();
   endtask

   task automatic test_extremes();
      load_config(1'b1, 32'd64, 32'd32, 32'd0, 32'h0003_8000, 32'hFFFE_0000,
                  32'd32768, 32'd65536);
      send_pose(mk_pose(0, 0, 16'sh0100, 16'sh0100, 0, 0, 0));
      send_pose(mk_pose(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0));
      send_pose(mk_pose(32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh8000, 0, 0, 0));
      send_pose(mk_pose(0, 0, -16'sh0100, 16'sh0200, 0, 0, 16'sd11520));
      send_pose(mk_pose(0, 0, 16'sh0100, 16'sh0100, 16'sd5760, -16'sd5760, 16'sd2880));
      send_pose(mk_pose(0, 0, 16'sh0100, 16'sh0100, 16'sd23040, -16'sd23040, -16'sd11520));
      send_pose(mk_pose(0, 0, 16'sh0100, 16'sh0100, 16'sd11520, 16'sd8640, 16'sd17280));
      send_pose(mk_pose(32'sh0010_0000, 0, 16'sh0100, 16'sh0100, -16'sd11520, 16'sd5761,
                        -16'sd5761));
      send_pose(mk_pose(0, 32'sh0010_0000, 16'sh0000, 16'sh0000, 16'sd1, -16'sd1, 16'sd1));
      drain();
      // Huge region at one pixel per unit drives the sizes into saturation.
      load_config(1'b1, 32'd8191, 32'd8191, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'd0, 32'd0);
      send_pose(mk_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF, 16'sh8000, 0, 0, 16'sd2880));
      send_pose(mk_pose(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh7FFF, 0, 0, -16'sd8640));
      send_pose(mk_pose(0, 0, 16'sh7FFF, 16'sh7FFF, 16'sd23040, 16'sd23040, 16'sd23040));
      drain();
   endtask

   task automatic test_not_drawn();
      // Disabled sprite with a valid region.
      load_config(1'b0, 32'd16, 32'd16, 32'd4096, 32'h0001_0000, 32'h0001_0000,
                  32'h0001_FFFF, 32'hFFFF_FFFF);
      send_pose(mk_pose(32'sh0004_0000, 32'sh0004_0000, 16'sh0100, 16'sh0100, 0, 0, 16'sd640));
      drain();
      // Enabled but one region side empty.
      write_reg(CSR_ENABLE, 32'd1);
      write_reg(CSR_REGION_WIDTH, 32'd0);
      send_pose(mk_pose(32'sh0004_0000, 0, 16'sh0100, 16'sh0100, 0, 0, 0));
      drain();
      write_reg(CSR_REGION_WIDTH, 32'd5000);
      write_reg(CSR_REGION_HEIGHT, 32'd0);
      send_pose(mk_pose(0, 32'sh0004_0000, 16'sh0100, 16'sh0100, 0, 0, 0));
      drain();
      // Writes beyond the register list must leave everything unchanged.
      write_reg(CSR_REGION_HEIGHT, 32'd7);
      write_reg(CSR_INDEX_UNUSED, 32'hFFFF_FFFF);
      write_reg(CSR_INDEX_HIGHEST, 32'hFFFF_FFFF);
      send_pose(mk_pose(32'sh0001_0000, 32'sh0001_0000, 16'sh0180, -16'sh0080, 16'sd960,
                        16'sd1920, -16'sd3000));
      drain();
   endtask

   task automatic test_random_phases();
      logic [31:0] rw;
      logic [31:0] rh;
      logic [31:0] ppu;
      logic [31:0] pvx;
      logic [31:0] pvy;
      for (int phase = 0; phase < 12; phase++) begin
         rw = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 8191);
         rh = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 512);
         ppu = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 8191);
         pvx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536);
         pvy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536);
         load_config($urandom_range(0, 3) != 0, rw, rh, ppu, $urandom, $urandom, pvx, pvy);
         for (int k = 0; k < 90; k++) send_pose(rand_pose());
         drain();
      end
   endtask

   // Result side: random stall and ready stretches, some long, some none.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 99) < 65) begin
         rsp_ready <= 1'b1;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(0, 6);
      end else begin
         rsp_ready <= 1'b0;
         ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 2);
      end
   end

   // Compare every accepted rectangle beat with the oldest prediction.
   always @(posedge clock) begin
      rect_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rects.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected rect beat: x=%h y=%h", rsp_dest_x, rsp_dest_y);
         end else begin
            want = pending_rects.pop_front();
            if (rsp_dest_x !== want.dest_x || rsp_dest_y !== want.dest_y ||
                rsp_dest_w !== want.dest_w || rsp_dest_h !== want.dest_h ||
                rsp_spin_out_deg !== want.spin || rsp_drawn !== want.drawn) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("rect mismatch exp x=%h y=%h w=%h h=%h spin=%h drawn=%b",
                           want.dest_x, want.dest_y, want.dest_w, want.dest_h,
                           want.spin, want.drawn);
                  $display("               got x=%h y=%h w=%h h=%h spin=%h drawn=%b",
                           rsp_dest_x, rsp_dest_y, rsp_dest_w, rsp_dest_h,
                           rsp_spin_out_deg, rsp_drawn);
               end
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_scale_x = '0;
      req_scale_y = '0;
      req_tilt_x_deg = '0;
      req_tilt_y_deg = '0;
      req_spin_z_deg = '0;
      rsp_ready = 1'b0;
      sh_enable = 1'b0;
      sh_region_w = '0;
      sh_region_h = '0;
      sh_ppu = PPU_DEFAULT;
      sh_offset_x = 0;
      sh_offset_y = 0;
      sh_pivot_x = 32768;
      sh_pivot_y = 32768;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_extremes();
      test_not_drawn();
      test_random_phases();

      drain();
      if (error_count == 0 && pending_rects.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
